// ===== hw/rtl/eps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_pkg
// shared widths and defaults for the exclusive product scan block
// ----------------------------------------------------------------------------
package eps_pkg;

	localparam int DATA_W      = 32;
	localparam int POS_W       = 6;
	localparam int MAX_LEN_DEF = 64;

endpackage

// ===== hw/rtl/eps_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module eps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/eps_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_front
// accepts list elements, writes them into the current bank and closes a
// list on the last marker or at capacity by pushing a job
// ----------------------------------------------------------------------------
module eps_front import eps_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic signed [DATA_W-1:0]           value,
	input  logic                               is_last,
	input  logic                               job_full,
	output logic                               job_push,
	output logic                               job_bank,
	output logic [$clog2(MAX_LEN+1)-1:0]       job_cnt,
	output logic                               mem_wr_en,
	output logic [$clog2(MAX_LEN):0]           mem_wr_addr,
	output logic [DATA_W-1:0]                  mem_wr_data
);

	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int CNT_W = $clog2(MAX_LEN + 1);

	logic             run_q;
	logic             bank_q;
	logic [CNT_W-1:0] wr_cnt_q;
	logic [CNT_W-1:0] cnt_nxt;
	logic             accept;
	logic             close;

	assign item_stall  = job_full | ~run_q;
	assign accept      = item_valid & ~item_stall;
	assign cnt_nxt     = wr_cnt_q + CNT_W'(1);
	// a list also closes once it reaches capacity
	assign close       = is_last | (cnt_nxt == CNT_W'(MAX_LEN));

	assign mem_wr_en   = accept;
	assign mem_wr_addr = {bank_q, wr_cnt_q[IDX_W-1:0]};
	assign mem_wr_data = DATA_W'(unsigned'(value));

	assign job_push    = accept & close;
	assign job_bank    = bank_q;
	assign job_cnt     = cnt_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			bank_q   <= 1'b0;
			wr_cnt_q <= '0;
		end else begin
			run_q <= 1'b1;
			if (accept) begin
				if (close) begin
					wr_cnt_q <= '0;
					bank_q   <= ~bank_q;
				end else begin
					wr_cnt_q <= cnt_nxt;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/eps_job_q.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_job_q
// two entry queue of closed lists (bank and length) between front and back
// ----------------------------------------------------------------------------
module eps_job_q #(
	parameter int CNT_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             push_bank,
	input  logic [CNT_W-1:0] push_cnt,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic             head_bank,
	output logic [CNT_W-1:0] head_cnt
);

	logic             bank_q [2];
	logic [CNT_W-1:0] cnt_q  [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;

	assign full       = fill_q[1];
	assign head_valid = (fill_q != 2'd0);
	assign head_bank  = bank_q[rd_ptr_q];
	assign head_cnt   = cnt_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			bank_q[wr_ptr_q] <= push_bank;
			cnt_q[wr_ptr_q]  <= push_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/eps_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_back
// runs one list: a backward pass storing suffix products, then a forward
// pass that multiplies each by the running prefix and emits the results
// ----------------------------------------------------------------------------
module eps_back import eps_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               job_valid,
	input  logic                               job_bank,
	input  logic [$clog2(MAX_LEN+1)-1:0]       job_cnt,
	output logic                               job_pop,
	output logic                               mem_rd_en,
	output logic [$clog2(MAX_LEN):0]           mem_rd_addr,
	input  logic [DATA_W-1:0]                  mem_rd_data,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic signed [DATA_W-1:0]           product,
	output logic [POS_W-1:0]                   position,
	output logic                               end_of_list
);

	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int CNT_W = $clog2(MAX_LEN + 1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_BW_RD  = 6'b000010,
		ST_BW_MUL = 6'b000100,
		ST_FW_RD  = 6'b001000,
		ST_FW_MUL = 6'b010000,
		ST_EMIT   = 6'b100000
	} back_state_t;

	back_state_t      state_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] i_q;
	logic [DATA_W-1:0] suf_q;
	logic [DATA_W-1:0] pre_q;
	logic [IDX_W-1:0] last_idx;
	logic             res_valid_q;
	logic [DATA_W-1:0] res_prod_q;
	logic [POS_W-1:0] res_pos_q;
	logic             res_end_q;
	logic             res_take;

	logic             sp_wr_en;
	logic             sp_rd_en;
	logic [DATA_W-1:0] sp_rd_data;

	assign last_idx = IDX_W'(job_cnt - CNT_W'(1));
	assign res_take = res_valid_q & ~result_stall;

	assign mem_rd_en   = (state_q == ST_BW_RD) | (state_q == ST_FW_RD);
	assign mem_rd_addr = {job_bank, (state_q == ST_BW_RD) ? k_q : i_q};

	// suffix store: entry k holds the product of the elements after k
	assign sp_wr_en = (state_q == ST_BW_RD);
	assign sp_rd_en = (state_q == ST_FW_RD);

	eps_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_LEN)
	) u_suffix_ram (
		.clk     (clk),
		.wr_en   (sp_wr_en),
		.wr_addr (k_q),
		.wr_data (suf_q),
		.rd_en   (sp_rd_en),
		.rd_addr (i_q),
		.rd_data (sp_rd_data)
	);

	assign job_pop      = res_take & res_end_q;
	assign result_valid = res_valid_q;
	assign product      = signed'(res_prod_q);
	assign position     = res_pos_q;
	assign end_of_list  = res_end_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				k_q   <= last_idx;
				suf_q <= DATA_W'(1);
			end
			ST_BW_MUL: begin
				suf_q <= suf_q * mem_rd_data;
				k_q   <= k_q - IDX_W'(1);
				i_q   <= '0;
				pre_q <= DATA_W'(1);
			end
			ST_FW_MUL: begin
				res_prod_q <= sp_rd_data * pre_q;
				res_pos_q  <= POS_W'(i_q);
				res_end_q  <= (i_q == last_idx);
				pre_q      <= pre_q * mem_rd_data;
			end
			ST_EMIT: begin
				if (res_take) begin
					i_q <= i_q + IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_BW_RD;
					end
				end
				ST_BW_RD: begin
					state_q <= ST_BW_MUL;
				end
				ST_BW_MUL: begin
					state_q <= (k_q == '0) ? ST_FW_RD : ST_BW_RD;
				end
				ST_FW_RD: begin
					state_q <= ST_FW_MUL;
				end
				ST_FW_MUL: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (res_take) begin
						res_valid_q <= 1'b0;
						state_q     <= res_end_q ? ST_IDLE : ST_FW_RD;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					res_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/exclusive_product_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exclusive_product_scan
// product of all other elements for each position of a list, wrapped to 32b
// ----------------------------------------------------------------------------
// the first result of an n element list follows the whole backward pass over it;
//   results then come in position order, each taken before the next is computed
// the work is set by the back part's two passes, each one element ram read and
//   one registered multiply step per element
// loading a list overlaps the previous one's work (two element ram banks)
// reset clears all control state; the rams need no clearing pass
// ----------------------------------------------------------------------------
module exclusive_product_scan import eps_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     is_last,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [DATA_W-1:0] product,
	output logic [POS_W-1:0]         position,
	output logic                     end_of_list
);

	localparam int CNT_W  = $clog2(MAX_LEN + 1);
	localparam int ADDR_W = $clog2(MAX_LEN) + 1;

	logic              job_full;
	logic              job_push;
	logic              job_push_bank;
	logic [CNT_W-1:0]  job_push_cnt;
	logic              job_pop;
	logic              job_valid;
	logic              job_bank;
	logic [CNT_W-1:0]  job_cnt;
	logic              el_wr_en;
	logic [ADDR_W-1:0] el_wr_addr;
	logic [DATA_W-1:0] el_wr_data;
	logic              el_rd_en;
	logic [ADDR_W-1:0] el_rd_addr;
	logic [DATA_W-1:0] el_rd_data;

	eps_front #(
		.MAX_LEN (MAX_LEN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.value       (value),
		.is_last     (is_last),
		.job_full    (job_full),
		.job_push    (job_push),
		.job_bank    (job_push_bank),
		.job_cnt     (job_push_cnt),
		.mem_wr_en   (el_wr_en),
		.mem_wr_addr (el_wr_addr),
		.mem_wr_data (el_wr_data)
	);

	// two banks: one is loaded while the other is worked on
	eps_ram #(
		.WIDTH (DATA_W),
		.DEPTH (2 ** ADDR_W)
	) u_element_ram (
		.clk     (clk),
		.wr_en   (el_wr_en),
		.wr_addr (el_wr_addr),
		.wr_data (el_wr_data),
		.rd_en   (el_rd_en),
		.rd_addr (el_rd_addr),
		.rd_data (el_rd_data)
	);

	eps_job_q #(
		.CNT_W (CNT_W)
	) u_job_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_bank  (job_push_bank),
		.push_cnt   (job_push_cnt),
		.full       (job_full),
		.pop        (job_pop),
		.head_valid (job_valid),
		.head_bank  (job_bank),
		.head_cnt   (job_cnt)
	);

	eps_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job_bank     (job_bank),
		.job_cnt      (job_cnt),
		.job_pop      (job_pop),
		.mem_rd_en    (el_rd_en),
		.mem_rd_addr  (el_rd_addr),
		.mem_rd_data  (el_rd_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.product      (product),
		.position     (position),
		.end_of_list  (end_of_list)
	);

endmodule

// ===== hw/rtl/eps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eps_checker
// port level checks of the exclusive product scan, bound to the top level
// ----------------------------------------------------------------------------
module eps_checker import eps_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     item_valid,
	input logic                     item_stall,
	input logic                     result_valid,
	input logic                     result_stall,
	input logic signed [DATA_W-1:0] product,
	input logic [POS_W-1:0]         position,
	input logic                     end_of_list
);

	// a stalled result transaction stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result valid dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			$stable(product) && $stable(position) && $stable(end_of_list))
		else $error("result payload changed while stalled");

	// a single element list has the empty product
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && end_of_list && (position == '0) |-> (product == DATA_W'(1)))
		else $error("single element list did not give one");

	// input stall only rises after a list was closed; this checks only that an input item was valid
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_stall) |-> $past(item_valid))
		else $error("input stall rose without an input transaction");

endmodule

bind exclusive_product_scan eps_checker u_eps_checker (.*);
